@@ rtl/sd_spi_host_sequencer_macros.svh @@
// Assertion macros for the checker of the SD SPI host sequencer.
// Depends on nothing; included by the checker module.
`ifndef SD_SPI_HOST_SEQUENCER_MACROS_SVH
`define SD_SPI_HOST_SEQUENCER_MACROS_SVH
// Property that holds on every clock edge outside reset.
`define SDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked at every clock edge, also during reset.
`define SDS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ rtl/sdsh_pkg.sv @@
// Package of the SD SPI host sequencer: payload structs, codes and constants.
// Depends on nothing; used by every module of the block.
package sdsh_pkg;

   localparam int BLOCK_BYTES_DEFAULT = 512;

   localparam logic [2:0] CMD_INIT  = 3'd0;
   localparam logic [2:0] CMD_READ  = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_REPLY = 3'd3;
   localparam logic [2:0] CMD_WDATA = 3'd4;

   localparam logic [1:0] KIND_SEND  = 2'd0;
   localparam logic [1:0] KIND_RDATA = 2'd1;
   localparam logic [1:0] KIND_WREQ  = 2'd2;
   localparam logic [1:0] KIND_DONE  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ERROR    = 2'd1;
   localparam logic [1:0] ST_NOTREADY = 2'd2;
   localparam logic [1:0] ST_INITFAIL = 2'd3;

   localparam logic [1:0] REG_RESP_POLL  = 2'd0;
   localparam logic [1:0] REG_INIT_RETRY = 2'd1;
   localparam logic [1:0] REG_TOKEN_POLL = 2'd2;
   localparam logic [1:0] REG_WAKEUP     = 2'd3;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  drive;
      logic [31:0] sector;
      logic [15:0] block_count;
      logic [7:0]  byte_value;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       select_low;
      logic       fast_clock;
      logic [1:0] status;
      logic [1:0] card_kind;
      logic       ready_res;
      logic       last;
   } rsp_type;

endpackage

@@ rtl/sd_spi_host_sequencer.sv @@
// SD card SPI-mode host byte sequencer: init, block read and block write.
// An accepted request's results are registered in the result queue.
// Throughput: one request per cycle while the four-entry result queue has
// room for two results; the queue is the only place that stalls the input.
// Reset: synchronous, active high; phase idle, select released, slow clock,
// card not initialised, configuration registers at their defaults.
module sd_spi_host_sequencer #(
   parameter int BLOCK_BYTES = sdsh_pkg::BLOCK_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sdsh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sdsh_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);

   localparam int BW = $clog2(BLOCK_BYTES + 1);

   // Sequencer phases, one per step of the SPI command flow.
   typedef enum logic [4:0] {
      PH_IDLE, PH_CMD0, PH_CMD8, PH_A55V2, PH_A41V2, PH_CMD58, PH_A55V1,
      PH_A41V1, PH_CMD1, PH_CMD16, PH_RDCMD, PH_CMD12, PH_WRCMD, PH_WAKE,
      PH_R7, PH_OCR, PH_RDTOK, PH_RDDATA, PH_RDCRC, PH_WRTOK, PH_WRREQ,
      PH_WRSENT, PH_WRCRC, PH_WRRESP, PH_WRSTOP
   } phase_type;

   // Configuration registers.
   logic [7:0]  resp_poll_ff, wakeup_ff;
   logic [15:0] init_retry_ff, token_poll_ff;

   // Sequencer state and its next values.
   phase_type   phase_ff, phase_in;
   logic [2:0]  frame_ff, frame_in;
   logic [5:0]  opcode_ff, opcode_in;
   logic [31:0] arg_ff, arg_in;
   logic [15:0] poll_ff, poll_in;
   logic [15:0] loop_ff, loop_in;
   logic [BW-1:0] bib_ff, bib_in;
   logic [15:0] blocks_ff, blocks_in;
   logic [1:0]  ctype_ff, ctype_in;
   logic        init_ff, init_in;
   logic        sel_ff, sel_in;
   logic        speed_ff, speed_in;

   // Up to two results per request.
   logic        push_a, push_b;
   logic [1:0]  kind_a, kind_b, stat_a, stat_b;
   logic [7:0]  byte_a, byte_b;
   logic        room_two, accept;
   sdsh_pkg::rsp_type res_a, res_b;

   assign req_stall = !room_two;
   assign accept    = req_valid && room_two;

   // Byte of the command frame at a given index for the current opcode.
   function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [5:0] op,
                                             input logic [31:0] arg);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'hFF;
         3'd1:    b = {2'b01, op};
         3'd2:    b = arg[31:24];
         3'd3:    b = arg[23:16];
         3'd4:    b = arg[15:8];
         3'd5:    b = arg[7:0];
         default: b = (op == 6'd0) ? 8'h95 : (op == 6'd8) ? 8'h87 : 8'hFF;
      endcase
      return b;
   endfunction

   always_comb begin
      logic [7:0]  r;
      logic [15:0] pc, lc, bl;
      logic [BW-1:0] bb;
      logic        cmd_fin;
      phase_type   cph;
      logic [5:0]  cop;
      logic [31:0] carg;
      logic        start;
      logic        fin;
      logic [1:0]  fst;
      logic        snd;
      logic [7:0]  sbyte;

      phase_in  = phase_ff;
      frame_in  = frame_ff;
      opcode_in = opcode_ff;
      arg_in    = arg_ff;
      poll_in   = poll_ff;
      loop_in   = loop_ff;
      bib_in    = bib_ff;
      blocks_in = blocks_ff;
      ctype_in  = ctype_ff;
      init_in   = init_ff;
      sel_in    = sel_ff;
      speed_in  = speed_ff;
      push_a = 1'b0; push_b = 1'b0;
      kind_a = sdsh_pkg::KIND_SEND; kind_b = sdsh_pkg::KIND_SEND;
      byte_a = 8'h00; byte_b = 8'h00;
      stat_a = sdsh_pkg::ST_OK; stat_b = sdsh_pkg::ST_OK;

      r = req_data.byte_value;
      pc = poll_ff + 16'd1;
      lc = loop_ff + 16'd1;
      bl = blocks_ff - 16'd1;
      bb = bib_ff + BW'(1);
      start = 1'b0; cph = PH_IDLE; cop = 6'd0; carg = 32'd0;
      fin = 1'b0; fst = sdsh_pkg::ST_OK;
      snd = 1'b0; sbyte = 8'hFF;
      cmd_fin = 1'b0;

      if (accept) begin
         case (req_data.command)
            sdsh_pkg::CMD_INIT: begin
               if (phase_ff == PH_IDLE) begin
                  if (req_data.drive != 8'd0) begin
                     push_a = 1'b1; kind_a = sdsh_pkg::KIND_DONE;
                     stat_a = sdsh_pkg::ST_INITFAIL;
                  end else if (init_ff) begin
                     push_a = 1'b1; kind_a = sdsh_pkg::KIND_DONE;
                  end else begin
                     speed_in = 1'b0;
                     sel_in   = 1'b0;
                     if (wakeup_ff == 8'd0) begin
                        sel_in = 1'b1; loop_in = 16'd0;
                        start = 1'b1; cph = PH_CMD0;
                     end else begin
                        phase_in = PH_WAKE; loop_in = 16'd0; snd = 1'b1;
                     end
                  end
               end
            end
            sdsh_pkg::CMD_READ, sdsh_pkg::CMD_WRITE: begin
               if (phase_ff == PH_IDLE) begin
                  if (req_data.drive != 8'd0 || !init_ff) begin
                     push_a = 1'b1; kind_a = sdsh_pkg::KIND_DONE;
                     stat_a = sdsh_pkg::ST_NOTREADY;
                  end else begin
                     sel_in = 1'b1;
                     blocks_in = req_data.block_count;
                     start = 1'b1; carg = req_data.sector;
                     if (req_data.command == sdsh_pkg::CMD_WRITE) begin
                        cph = PH_WRCMD;
                        cop = (req_data.block_count == 16'd1) ? 6'd24 : 6'd25;
                     end else begin
                        cph = PH_RDCMD;
                        cop = (req_data.block_count == 16'd1) ? 6'd17 : 6'd18;
                     end
                  end
               end
            end
            sdsh_pkg::CMD_WDATA: begin
               if (phase_ff == PH_WRREQ) begin
                  phase_in = PH_WRSENT;
                  snd = 1'b1; sbyte = r;
               end
            end
            sdsh_pkg::CMD_REPLY: begin
               if (phase_ff >= PH_CMD0 && phase_ff <= PH_WRCMD) begin
                  if (frame_ff < 3'd7) begin
                     frame_in = frame_ff + 3'd1;
                     snd = 1'b1;
                     if (frame_ff + 3'd1 < 3'd7) begin
                        sbyte = frame_byte(frame_ff + 3'd1, opcode_ff, arg_ff);
                     end else begin
                        poll_in = 16'd0;
                     end
                  end else begin
                     poll_in = pc;
                     if (r[7] && pc < {8'd0, resp_poll_ff}) snd = 1'b1;
                     else cmd_fin = 1'b1;
                  end
               end else begin
                  case (phase_ff)
                     PH_WAKE: begin
                        loop_in = lc;
                        if (lc < {8'd0, wakeup_ff}) snd = 1'b1;
                        else begin
                           sel_in = 1'b1; loop_in = 16'd0;
                           start = 1'b1; cph = PH_CMD0;
                        end
                     end
                     PH_R7, PH_OCR: begin
                        bib_in = bb;
                        if (bb < BW'(4)) snd = 1'b1;
                        else if (phase_ff == PH_R7) begin
                           loop_in = 16'd0; start = 1'b1; cph = PH_A55V2; cop = 6'd55;
                        end else begin
                           start = 1'b1; cph = PH_CMD16; cop = 6'd16;
                           carg = 32'(BLOCK_BYTES);
                        end
                     end
                     PH_RDTOK: begin
                        poll_in = pc;
                        if (r == 8'hFF && pc < token_poll_ff) snd = 1'b1;
                        else if (r != 8'hFE) begin fin = 1'b1; fst = sdsh_pkg::ST_ERROR; end
                        else begin phase_in = PH_RDDATA; bib_in = '0; snd = 1'b1; end
                     end
                     PH_RDDATA: begin
                        // Data byte first, then the next poll byte.
                        push_a = 1'b1; kind_a = sdsh_pkg::KIND_RDATA; byte_a = r;
                        bib_in = bb;
                        if (bb >= BW'(BLOCK_BYTES)) begin
                           phase_in = PH_RDCRC; bib_in = '0;
                        end
                        push_b = 1'b1; byte_b = 8'hFF;
                     end
                     PH_RDCRC: begin
                        bib_in = bb;
                        if (bb < BW'(2)) snd = 1'b1;
                        else begin
                           blocks_in = bl;
                           if (bl != 16'd0) begin
                              phase_in = PH_RDTOK; poll_in = 16'd0; snd = 1'b1;
                           end else if (opcode_ff == 6'd18) begin
                              start = 1'b1; cph = PH_CMD12; cop = 6'd12;
                           end else fin = 1'b1;
                        end
                     end
                     PH_WRTOK: begin
                        phase_in = PH_WRREQ; bib_in = '0;
                        push_a = 1'b1; kind_a = sdsh_pkg::KIND_WREQ;
                     end
                     PH_WRSENT: begin
                        bib_in = bb;
                        if (bb < BW'(BLOCK_BYTES)) begin
                           phase_in = PH_WRREQ;
                           push_a = 1'b1; kind_a = sdsh_pkg::KIND_WREQ;
                        end else begin
                           phase_in = PH_WRCRC; bib_in = '0; snd = 1'b1;
                        end
                     end
                     PH_WRCRC: begin
                        bib_in = bb;
                        if (bb >= BW'(2)) phase_in = PH_WRRESP;
                        snd = 1'b1;
                     end
                     PH_WRRESP: begin
                        if (r[4:0] != 5'h05) begin fin = 1'b1; fst = sdsh_pkg::ST_ERROR; end
                        else begin
                           blocks_in = bl;
                           if (bl != 16'd0) begin
                              phase_in = PH_WRTOK; snd = 1'b1;
                              sbyte = (opcode_ff == 6'd24) ? 8'hFE : 8'hFC;
                           end else if (opcode_ff == 6'd25) begin
                              phase_in = PH_WRSTOP; bib_in = '0; snd = 1'b1; sbyte = 8'hFD;
                           end else fin = 1'b1;
                        end
                     end
                     PH_WRSTOP: begin
                        bib_in = bb;
                        if (bb < BW'(2)) snd = 1'b1;
                        else fin = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase

         // Completion of a command response.
         if (cmd_fin) begin
            case (phase_ff)
               PH_CMD0: begin
                  loop_in = lc;
                  if (r == 8'h01) begin
                     start = 1'b1; cph = PH_CMD8; cop = 6'd8; carg = 32'h0000_01AA;
                  end else if (lc < init_retry_ff) begin
                     start = 1'b1; cph = PH_CMD0;
                  end else begin fin = 1'b1; fst = sdsh_pkg::ST_INITFAIL; end
               end
               PH_CMD8: begin
                  if (r == 8'h01) begin
                     ctype_in = 2'd2; phase_in = PH_R7; bib_in = '0; snd = 1'b1;
                  end else begin
                     ctype_in = 2'd1; loop_in = 16'd0;
                     start = 1'b1; cph = PH_A55V1; cop = 6'd55;
                  end
               end
               PH_A55V2: begin
                  start = 1'b1; cph = PH_A41V2; cop = 6'd41; carg = 32'h4000_0000;
               end
               PH_A41V2: begin
                  loop_in = lc;
                  if (r == 8'h00) begin start = 1'b1; cph = PH_CMD58; cop = 6'd58; end
                  else if (lc < init_retry_ff) begin
                     start = 1'b1; cph = PH_A55V2; cop = 6'd55;
                  end else begin fin = 1'b1; fst = sdsh_pkg::ST_INITFAIL; end
               end
               PH_CMD58: begin
                  phase_in = PH_OCR; bib_in = '0; snd = 1'b1;
               end
               PH_A55V1: begin start = 1'b1; cph = PH_A41V1; cop = 6'd41; end
               PH_A41V1: begin
                  loop_in = lc;
                  if (r == 8'h00) begin
                     start = 1'b1; cph = PH_CMD16; cop = 6'd16; carg = 32'(BLOCK_BYTES);
                  end else if (lc < init_retry_ff) begin
                     start = 1'b1; cph = PH_A55V1; cop = 6'd55;
                  end else begin
                     loop_in = 16'd0; start = 1'b1; cph = PH_CMD1; cop = 6'd1;
                  end
               end
               PH_CMD1: begin
                  loop_in = lc;
                  if (r == 8'h00) begin
                     ctype_in = 2'd0;
                     start = 1'b1; cph = PH_CMD16; cop = 6'd16; carg = 32'(BLOCK_BYTES);
                  end else if (lc < init_retry_ff) begin
                     start = 1'b1; cph = PH_CMD1; cop = 6'd1;
                  end else begin fin = 1'b1; fst = sdsh_pkg::ST_INITFAIL; end
               end
               PH_CMD16: begin
                  speed_in = 1'b1; init_in = 1'b1; fin = 1'b1;
               end
               PH_RDCMD: begin
                  if (r != 8'h00) begin fin = 1'b1; fst = sdsh_pkg::ST_ERROR; end
                  else if (blocks_ff == 16'd0) begin
                     start = 1'b1; cph = PH_CMD12; cop = 6'd12;
                  end else begin
                     phase_in = PH_RDTOK; poll_in = 16'd0; snd = 1'b1;
                  end
               end
               PH_CMD12: fin = 1'b1;
               default: begin
                  if (r != 8'h00) begin fin = 1'b1; fst = sdsh_pkg::ST_ERROR; end
                  else if (blocks_ff == 16'd0) begin
                     phase_in = PH_WRSTOP; bib_in = '0; snd = 1'b1; sbyte = 8'hFD;
                  end else begin
                     phase_in = PH_WRTOK; snd = 1'b1;
                     sbyte = (opcode_ff == 6'd24) ? 8'hFE : 8'hFC;
                  end
               end
            endcase
         end

         // A new command frame starts with its first byte, always 0xFF.
         if (start) begin
            phase_in = cph; opcode_in = cop; arg_in = carg;
            frame_in = 3'd0; poll_in = 16'd0;
            snd = 1'b1; sbyte = frame_byte(3'd0, cop, carg);
         end
         if (fin) begin
            sel_in = 1'b0; phase_in = PH_IDLE;
            push_a = 1'b1; kind_a = sdsh_pkg::KIND_DONE; stat_a = fst;
         end else if (snd) begin
            push_a = 1'b1; kind_a = sdsh_pkg::KIND_SEND; byte_a = sbyte;
         end
      end

      // Results carry the state as it stands after the request.
      res_a = '{kind: kind_a, data_byte: byte_a, select_low: sel_in, fast_clock: speed_in,
                status: stat_a, card_kind: ctype_in, ready_res: init_in, last: !push_b};
      res_b = '{kind: kind_b, data_byte: byte_b, select_low: sel_in, fast_clock: speed_in,
                status: stat_b, card_kind: ctype_in, ready_res: init_in, last: 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resp_poll_ff  <= 8'd10;
         init_retry_ff <= 16'd1000;
         token_poll_ff <= 16'd10000;
         wakeup_ff     <= 8'd10;
         phase_ff  <= PH_IDLE;
         frame_ff  <= 3'd0;
         opcode_ff <= 6'd0;
         arg_ff    <= 32'd0;
         poll_ff   <= 16'd0;
         loop_ff   <= 16'd0;
         bib_ff    <= '0;
         blocks_ff <= 16'd0;
         ctype_ff  <= 2'd0;
         init_ff   <= 1'b0;
         sel_ff    <= 1'b0;
         speed_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               sdsh_pkg::REG_RESP_POLL:  resp_poll_ff  <= csr_data[7:0];
               sdsh_pkg::REG_INIT_RETRY: init_retry_ff <= csr_data;
               sdsh_pkg::REG_TOKEN_POLL: token_poll_ff <= csr_data;
               sdsh_pkg::REG_WAKEUP:     wakeup_ff     <= csr_data[7:0];
               default: ;
            endcase
         end
         phase_ff  <= phase_in;
         frame_ff  <= frame_in;
         opcode_ff <= opcode_in;
         arg_ff    <= arg_in;
         poll_ff   <= poll_in;
         loop_ff   <= loop_in;
         bib_ff    <= bib_in;
         blocks_ff <= blocks_in;
         ctype_ff  <= ctype_in;
         init_ff   <= init_in;
         sel_ff    <= sel_in;
         speed_ff  <= speed_in;
      end
   end

   sdsh_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_a    (push_a),
      .push_b    (push_b),
      .data_a    (res_a),
      .data_b    (res_b),
      .room_two  (room_two),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/sdsh_out_queue.sv @@
// Output queue of the SD SPI host sequencer: holds up to four results.
// Depends on sdsh_pkg.
module sdsh_out_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_a,
   input  logic             push_b,
   input  sdsh_pkg::rsp_type data_a,
   input  sdsh_pkg::rsp_type data_b,
   output logic             room_two,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sdsh_pkg::rsp_type rsp_data
);

   sdsh_pkg::rsp_type slot_ff [4];
   sdsh_pkg::rsp_type slot_in [4];
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [2:0] base;

   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = slot_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   // Two free slots remain after this cycle's pop.
   assign room_two  = (count_ff <= 3'd2) || (pop && count_ff == 3'd3);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         slot_in[i] = pop ? slot_ff[i+1] : slot_ff[i];
      end
      slot_in[3] = slot_ff[3];
      base = pop ? count_ff - 3'd1 : count_ff;
      if (push_a) begin
         slot_in[base[1:0]] = data_a;
         if (push_b) slot_in[base[1:0] + 2'd1] = data_b;
      end
      count_in = base + {2'd0, push_a} + {2'd0, push_a && push_b};
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) slot_ff[i] <= slot_in[i];
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/sdsh_checker.sv @@
// Port checker of the SD SPI host sequencer, bound to the top level.
// Depends on sdsh_pkg and sd_spi_host_sequencer_macros.svh.
`include "sd_spi_host_sequencer_macros.svh"
module sdsh_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sdsh_pkg::rsp_type rsp_data
);

   `SDS_ASSERT(a_rsp_hold, clock, reset, $past(rsp_valid && rsp_stall) |-> rsp_valid && $stable(rsp_data), "stalled response changed")
   `SDS_ASSERT(a_fast_ready, clock, reset, rsp_valid && rsp_data.fast_clock |-> rsp_data.ready_res, "fast clock without init")
   `SDS_ASSERT(a_done_last, clock, reset, rsp_valid && rsp_data.kind == sdsh_pkg::KIND_DONE |-> rsp_data.last && !rsp_data.select_low, "done not last or select held")
   `SDS_ASSERT(a_rdata_more, clock, reset, rsp_valid && rsp_data.kind == sdsh_pkg::KIND_RDATA |-> !rsp_data.last, "read byte marked last")
   `SDS_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "response after reset")

endmodule

bind sd_spi_host_sequencer sdsh_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
